>>> design/page_buffer_pool_directory_assert.svh
// assertion macros used by the directory checker
`ifndef PAGE_BUFFER_POOL_DIRECTORY_ASSERT_SVH
`define PAGE_BUFFER_POOL_DIRECTORY_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PBPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page buffer pool directory check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define PBPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page buffer pool directory check failed");

`endif

>>> design/pbpd_pkg.sv
// types, codes and constants of the page buffer pool directory
`default_nettype none

package pbpd_pkg;

    localparam int PAGE_BITS       = 24;
    localparam int SLOT_FIELD_BITS = 3;
    localparam int DEF_SLOT_COUNT  = 8;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int MAX_RESULTS     = 8;
    localparam int FLUSH_CNT_BITS  = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [2:0] STATUS_HIT         = 3'd0;
    localparam logic [2:0] STATUS_FILLED      = 3'd1;
    localparam logic [2:0] STATUS_EVICTED     = 3'd2;
    localparam logic [2:0] STATUS_ALL_PINNED  = 3'd3;
    localparam logic [2:0] STATUS_PINNED      = 3'd4;
    localparam logic [2:0] STATUS_PIN_MISS    = 3'd5;
    localparam logic [2:0] STATUS_FLUSH_ENTRY = 3'd6;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [PAGE_BITS-1:0] page_number;
        logic                 pin_on_load;
    } pbpd_cmd_t;

    typedef struct packed {
        logic [2:0]                 status;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic                       load_needed;
        logic                       writeback_valid;
        logic [PAGE_BITS-1:0]       writeback_page;
        logic                       last;
    } pbpd_result_t;

endpackage

`default_nettype wire

>>> design/pbpd_slot_store.sv
// slot metadata memory with per-slot occupied bits
`default_nettype none

module pbpd_slot_store #(
    parameter int SLOT_COUNT = pbpd_pkg::DEF_SLOT_COUNT,
    parameter int COUNT_BITS = pbpd_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
    output logic                               rd_occupied,
    output logic [pbpd_pkg::PAGE_BITS-1:0]     rd_page,
    output logic                               rd_pinned,
    output logic                               rd_dirty,
    output logic [COUNT_BITS-1:0]              rd_count,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
    input  wire logic [pbpd_pkg::PAGE_BITS-1:0] wr_page,
    input  wire logic                          wr_pinned,
    input  wire logic                          wr_dirty,
    input  wire logic [COUNT_BITS-1:0]         wr_count
);
    import pbpd_pkg::*;

    localparam int ENTRY_BITS = PAGE_BITS + 2 + COUNT_BITS;

    logic [ENTRY_BITS-1:0] mem [SLOT_COUNT];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic [SLOT_COUNT-1:0] occ_reg;
    logic                  rd_occ_reg;

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_page, wr_pinned, wr_dirty, wr_count};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // occupied bits; a slot is never emptied once loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                occ_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_occ_reg <= occ_reg[rd_addr];
            end
        end
    end

    // a never-loaded slot reads as all zero
    always_comb
    begin
        rd_occupied = rd_occ_reg;
        {rd_page, rd_pinned, rd_dirty, rd_count} = rd_occ_reg ? rd_data_reg : '0;
    end

endmodule

`default_nettype wire

>>> design/page_buffer_pool_directory.sv
// top level of the page buffer pool directory
`default_nettype none

// Page buffer pool directory. A command beat is taken when start is high and
// busy is low. Read and write accesses, pins and flushes all scan the slot
// memory one slot per cycle through its single read port, so every command
// keeps busy high after it is taken while it issues SLOT_COUNT reads, waits
// for the last read data to return and then makes its update in the finish
// state. Results come out on result with done high for one cycle each
// and cannot be held off. Access and pin give one result, shown in the cycle
// in which busy drops. A flush gives one result per dirty occupied slot, in
// slot order, at most eight, overlapping the scan; a flush with nothing
// dirty gives no result at all. last marks the final result of a command.
// No clearing pass is needed after reset: per-slot occupied flops mask the
// memory contents until a slot is first loaded.
module page_buffer_pool_directory #(
    parameter int SLOT_COUNT = pbpd_pkg::DEF_SLOT_COUNT,
    parameter int COUNT_BITS = pbpd_pkg::DEF_COUNT_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire pbpd_pkg::pbpd_cmd_t     cmd,
    output logic                         done,
    output pbpd_pkg::pbpd_result_t       result
);
    import pbpd_pkg::*;

    localparam int IDX_BITS = $clog2(SLOT_COUNT);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOT_COUNT - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;

    // latched command
    pbpd_cmd_t cmd_reg;

    // read issue and returning-data tracking
    logic                issue_on_reg;
    logic [IDX_BITS-1:0] issue_idx_reg;
    logic                data_on_reg;
    logic [IDX_BITS-1:0] data_idx_reg;

    // store read data
    logic                  d_occ;
    logic [PAGE_BITS-1:0]  d_page;
    logic                  d_pinned;
    logic                  d_dirty;
    logic [COUNT_BITS-1:0] d_count;

    // scan results: first hit
    logic                  hit_found_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg;
    logic                  hit_pinned_reg;
    logic                  hit_dirty_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;

    // scan results: lowest empty slot
    logic                  empty_found_reg;
    logic [IDX_BITS-1:0]   empty_idx_reg;

    // scan results: unpinned slot with smallest count, ties to higher index
    logic                  vic_found_reg;
    logic [IDX_BITS-1:0]   vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_count_reg;
    logic                  vic_dirty_reg;
    logic [PAGE_BITS-1:0]  vic_page_reg;

    // flush: one entry held back so the final one can carry last
    logic                      pend_valid_reg;
    logic [IDX_BITS-1:0]       pend_idx_reg;
    logic [PAGE_BITS-1:0]      pend_page_reg;
    logic [FLUSH_CNT_BITS-1:0] flush_n_reg;

    // store write port
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [PAGE_BITS-1:0]  wr_page;
    logic                  wr_pinned;
    logic                  wr_dirty;
    logic [COUNT_BITS-1:0] wr_count;

    // output register
    logic         done_reg, done_next;
    pbpd_result_t result_reg, result_next;
    logic [IDX_BITS-1:0] res_idx;
    logic [IDX_BITS+2:0] res_idx_wide;

    logic accept;
    logic is_write;
    logic is_flush;
    logic flush_take;
    logic scan_done;
    logic hit_now;
    logic vic_now;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign is_write   = (cmd_reg.opcode == OP_WRITE);
    assign is_flush   = (cmd_reg.opcode == OP_FLUSH);
    assign scan_done  = data_on_reg && (data_idx_reg == LAST_IDX);

    // per-slot decisions on the returning beat of read data
    assign hit_now    = data_on_reg && d_occ && (d_page == cmd_reg.page_number)
                        && !hit_found_reg;
    assign vic_now    = data_on_reg && !d_pinned
                        && (!vic_found_reg || (d_count <= vic_count_reg));
    assign flush_take = data_on_reg && is_flush && d_occ && d_dirty
                        && (flush_n_reg < FLUSH_CNT_BITS'(MAX_RESULTS));

    pbpd_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (issue_on_reg),
        .rd_addr     (issue_idx_reg),
        .rd_occupied (d_occ),
        .rd_page     (d_page),
        .rd_pinned   (d_pinned),
        .rd_dirty    (d_dirty),
        .rd_count    (d_count),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_page     (wr_page),
        .wr_pinned   (wr_pinned),
        .wr_dirty    (wr_dirty),
        .wr_count    (wr_count)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // write-back decisions and the result beat
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = data_idx_reg;
        wr_page     = d_page;
        wr_pinned   = d_pinned;
        wr_dirty    = 1'b0;
        wr_count    = d_count;
        done_next   = 1'b0;
        result_next = '0;
        res_idx     = '0;

        if (state_reg == S_SCAN && flush_take)
        begin
            // clear dirty on the slot just read; emit the previous entry
            wr_en = 1'b1;
            if (pend_valid_reg)
            begin
                done_next                   = 1'b1;
                result_next.status          = STATUS_FLUSH_ENTRY;
                result_next.writeback_valid = 1'b1;
                result_next.writeback_page  = pend_page_reg;
                res_idx                     = pend_idx_reg;
            end
        end
        else if (state_reg == S_FINISH)
        begin
            case (cmd_reg.opcode)
                OP_READ, OP_WRITE:
                begin
                    done_next        = 1'b1;
                    result_next.last = 1'b1;
                    if (hit_found_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = hit_idx_reg;
                        wr_page   = cmd_reg.page_number;
                        wr_pinned = hit_pinned_reg;
                        wr_dirty  = hit_dirty_reg | is_write;
                        wr_count  = (hit_count_reg == '1) ? hit_count_reg
                                                          : hit_count_reg + 1'b1;
                        result_next.status = STATUS_HIT;
                        res_idx            = hit_idx_reg;
                    end
                    else if (empty_found_reg || vic_found_reg)
                    begin
                        // load the page into the chosen slot
                        wr_en                   = 1'b1;
                        wr_addr                 = empty_found_reg ? empty_idx_reg
                                                                  : vic_idx_reg;
                        wr_page                 = cmd_reg.page_number;
                        wr_pinned               = cmd_reg.pin_on_load;
                        wr_dirty                = is_write;
                        wr_count                = COUNT_BITS'(1);
                        result_next.load_needed = 1'b1;
                        res_idx                 = wr_addr;
                        if (empty_found_reg)
                        begin
                            result_next.status = STATUS_FILLED;
                        end
                        else
                        begin
                            result_next.status          = STATUS_EVICTED;
                            result_next.writeback_valid = vic_dirty_reg;
                            result_next.writeback_page  = vic_dirty_reg ? vic_page_reg
                                                                        : '0;
                        end
                    end
                    else
                    begin
                        result_next.status = STATUS_ALL_PINNED;
                    end
                end
                OP_PIN:
                begin
                    done_next        = 1'b1;
                    result_next.last = 1'b1;
                    if (hit_found_reg)
                    begin
                        wr_en              = 1'b1;
                        wr_addr            = hit_idx_reg;
                        wr_page            = cmd_reg.page_number;
                        wr_pinned          = 1'b1;
                        wr_dirty           = hit_dirty_reg;
                        wr_count           = hit_count_reg;
                        result_next.status = STATUS_PINNED;
                        res_idx            = hit_idx_reg;
                    end
                    else
                    begin
                        result_next.status = STATUS_PIN_MISS;
                    end
                end
                default:
                begin
                    // flush: the held entry is the final one
                    if (pend_valid_reg)
                    begin
                        done_next                   = 1'b1;
                        result_next.status          = STATUS_FLUSH_ENTRY;
                        result_next.writeback_valid = 1'b1;
                        result_next.writeback_page  = pend_page_reg;
                        result_next.last            = 1'b1;
                        res_idx                     = pend_idx_reg;
                    end
                end
            endcase
        end

        // slot field shows the low bits of the index
        res_idx_wide     = {3'b000, res_idx};
        result_next.slot = res_idx_wide[SLOT_FIELD_BITS-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            issue_on_reg    <= 1'b0;
            issue_idx_reg   <= '0;
            data_on_reg     <= 1'b0;
            data_idx_reg    <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            vic_found_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            flush_n_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            data_on_reg  <= issue_on_reg;
            data_idx_reg <= issue_idx_reg;

            if (accept)
            begin
                issue_on_reg    <= 1'b1;
                issue_idx_reg   <= '0;
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
                vic_found_reg   <= 1'b0;
                pend_valid_reg  <= 1'b0;
                flush_n_reg     <= '0;
            end
            else
            begin
                if (issue_on_reg)
                begin
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_on_reg <= 1'b0;
                    end
                    else
                    begin
                        issue_idx_reg <= issue_idx_reg + 1'b1;
                    end
                end
                if (hit_now)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (data_on_reg && !d_occ)
                begin
                    empty_found_reg <= 1'b1;
                end
                if (vic_now)
                begin
                    vic_found_reg <= 1'b1;
                end
                if (flush_take)
                begin
                    pend_valid_reg <= 1'b1;
                    flush_n_reg    <= flush_n_reg + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (hit_now)
        begin
            hit_idx_reg    <= data_idx_reg;
            hit_pinned_reg <= d_pinned;
            hit_dirty_reg  <= d_dirty;
            hit_count_reg  <= d_count;
        end
        if (data_on_reg && !d_occ && !empty_found_reg)
        begin
            empty_idx_reg <= data_idx_reg;
        end
        if (vic_now)
        begin
            vic_idx_reg   <= data_idx_reg;
            vic_count_reg <= d_count;
            vic_dirty_reg <= d_dirty;
            vic_page_reg  <= d_page;
        end
        if (flush_take)
        begin
            pend_idx_reg  <= data_idx_reg;
            pend_page_reg <= d_page;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> design/pbpd_checker.sv
// port-level checks of the page buffer pool directory and their bind
`default_nettype none

`include "page_buffer_pool_directory_assert.svh"

module pbpd_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   done,
    input wire pbpd_pkg::pbpd_result_t result
);
    import pbpd_pkg::*;

    logic load_status;

    // statuses that bring a page in from storage
    assign load_status = (result.status == STATUS_FILLED)
                         || (result.status == STATUS_EVICTED);

    // every result of a command other than flush carries last
    `PBPD_ASSERT_NOW(a_single_is_last, done && result.status != STATUS_FLUSH_ENTRY, result.last)

    // no writeback means a zero page
    `PBPD_ASSERT_NOW(a_wb_page_zero, done && !result.writeback_valid, result.writeback_page == '0)

    // load request only on fill or evict
    `PBPD_ASSERT_NOW(a_load_flag, done, result.load_needed == load_status)

    // a taken command raises busy
    `PBPD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // nothing follows the final beat directly
    `PBPD_ASSERT_NEXT(a_gap_after_last, done && result.last, !done)

endmodule

bind page_buffer_pool_directory pbpd_checker u_pbpd_checker (.*);

`default_nettype wire
